@@ src/rsf_pkg.sv @@
// ----------------------------------------------------------------------------
// rsf_pkg
// Shared types, constants and the header byte function of the raster framer.
// ----------------------------------------------------------------------------
package rsf_pkg;

  localparam int unsigned DimW     = 14;
  localparam int unsigned CompW    = 8;
  localparam int unsigned MapValW  = 16;
  localparam int unsigned MapEnW   = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned ByteIdxW = 6;
  localparam int unsigned LineW    = 16;
  localparam int unsigned LenW     = 32;

  localparam logic [31:0] RasMagic   = 32'h59a6_6a95;
  localparam logic [31:0] RasDepth   = 32'd24;
  localparam logic [31:0] RasTypeRgb = 32'd3;

  // Position of each byte within the bytes caused by one pixel.
  localparam logic [ByteIdxW-1:0] IdxRed   = 6'd32;
  localparam logic [ByteIdxW-1:0] IdxGreen = 6'd33;
  localparam logic [ByteIdxW-1:0] IdxBlue  = 6'd34;
  localparam logic [ByteIdxW-1:0] IdxPad   = 6'd35;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    MAP_RED   = 2'd0,
    MAP_GREEN = 2'd1,
    MAP_BLUE  = 2'd2,
    MAP_NONE  = 2'd3
  } map_sel_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MAP_EN = 2'd2,
    REG_NONE   = 2'd3
  } cfg_reg_e;

  // Byte of the 32-byte header at position idx, words sent big-endian.
  function automatic logic [7:0] header_byte(
    input logic [4:0]      idx,
    input logic [DimW-1:0] width,
    input logic [DimW-1:0] height,
    input logic [LenW-1:0] length
  );
    logic [31:0] word;
    logic [31:0] shifted;
    case (idx[4:2])
      3'd0:    word = RasMagic;
      3'd1:    word = {{(32-DimW){1'b0}}, width};
      3'd2:    word = {{(32-DimW){1'b0}}, height};
      3'd3:    word = RasDepth;
      3'd4:    word = length;
      3'd5:    word = RasTypeRgb;
      default: word = 32'd0;
    endcase
    shifted = word >> {~idx[1:0], 3'b000};
    return shifted[7:0];
  endfunction

endpackage

@@ src/rsf_if.sv @@
// ----------------------------------------------------------------------------
// rsf_if
// Channel interfaces of the raster framer: pixel/load input, byte output and
// configuration write.
// ----------------------------------------------------------------------------
interface rsf_in_if import rsf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [CompW-1:0]     red;
  logic [CompW-1:0]     green;
  logic [CompW-1:0]     blue;
  logic [1:0]           map_select;
  logic [CompW-1:0]     map_index;
  logic [MapValW-1:0]   map_value;

  modport source (output valid, cmd, red, green, blue, map_select, map_index,
                  map_value, input ready);
  modport sink   (input valid, cmd, red, green, blue, map_select, map_index,
                  map_value, output ready);
endinterface

interface rsf_out_if import rsf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [7:0]       out_byte;
  logic             last_of_item;
  logic             frame_done;

  modport source (output valid, out_byte, last_of_item, frame_done, input ready);
  modport sink   (input valid, out_byte, last_of_item, frame_done, output ready);
endinterface

interface rsf_cfg_if import rsf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DimW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/rgb_raster_stream_framer.sv @@
// ----------------------------------------------------------------------------
// rgb_raster_stream_framer
// Turns a stream of RGB pixels into the byte stream of a 24-bit rasterfile.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i carries map loads (cmd 0) and pixels (cmd 1) in output order. A
//   load writes the high byte of map_value into the selected map and yields
//   nothing. A pixel yields red, green and blue bytes on byte_o, preceded by
//   the 32-byte header on the first pixel of a frame and followed by a zero
//   pad byte at the end of each row when the width is odd.
//   cfg_i writes frame_width (0), frame_height (1) and map_enable (2); it is
//   always ready and must only be used while the block is idle.
// Byte flow:
//   The first byte of a pixel passes the pixel register, then the output
//   register, which sends one byte per cycle while byte_o is ready. A
//   pixel yields 3 bytes, 4 with a pad byte, 32 more with a header. The next
//   pixel is taken as its predecessor's last byte enters the output register.
// Reset:
//   Counters return to the start of a frame, width and height to 1 and all
//   maps disabled. Map contents are not cleared and must be loaded before
//   use. When byte_o is stalled the output register holds its byte and the
//   block stops taking items once its pixel register is full.
// ----------------------------------------------------------------------------
module rgb_raster_stream_framer import rsf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  rsf_in_if.sink  pix_i,
  rsf_out_if.source byte_o,
  rsf_cfg_if.sink cfg_i
);

  // Configuration registers.
  logic [DimW-1:0]   width_q, height_q;
  logic [MapEnW-1:0] map_en_q;
  logic [DimW-1:0]   width_eff, height_eff;
  logic [LineW-1:0]  line_len;
  logic [LenW-1:0]   length_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(1);
      height_q <= DimW'(1);
      map_en_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_WIDTH:  width_q  <= cfg_i.data;
        REG_HEIGHT: height_q <= cfg_i.data;
        REG_MAP_EN: map_en_q <= cfg_i.data[MapEnW-1:0];
        default:    ;
      endcase
    end
  end

  assign width_eff  = (width_q == '0)  ? DimW'(1) : width_q;
  assign height_eff = (height_q == '0) ? DimW'(1) : height_q;
  assign line_len   = LineW'({width_eff, 1'b0}) + LineW'(width_eff)
                    + LineW'(width_eff[0]);

  // Byte length is registered from the configuration; it is first needed for
  // the length word, header bytes 16 to 19.
  always_ff @(posedge clk_i) begin
    length_q <= LenW'(line_len * height_eff);
  end

  // Input handshake and map access.
  logic in_fire, load_fire, pix_fire;
  logic [CompW-1:0] red_map, green_map, blue_map;

  assign in_fire   = pix_i.valid && pix_i.ready;
  assign load_fire = in_fire && (cmd_e'(pix_i.cmd) == CMD_LOAD);
  assign pix_fire  = in_fire && (cmd_e'(pix_i.cmd) == CMD_PIXEL);

  rsf_map_ram u_red_map (
    .clk_i   (clk_i),
    .we_i    (load_fire && (map_sel_e'(pix_i.map_select) == MAP_RED)),
    .waddr_i (pix_i.map_index),
    .wdata_i (pix_i.map_value[MapValW-1 -: CompW]),
    .re_i    (pix_fire),
    .raddr_i (pix_i.red),
    .rdata_o (red_map)
  );

  rsf_map_ram u_green_map (
    .clk_i   (clk_i),
    .we_i    (load_fire && (map_sel_e'(pix_i.map_select) == MAP_GREEN)),
    .waddr_i (pix_i.map_index),
    .wdata_i (pix_i.map_value[MapValW-1 -: CompW]),
    .re_i    (pix_fire),
    .raddr_i (pix_i.green),
    .rdata_o (green_map)
  );

  rsf_map_ram u_blue_map (
    .clk_i   (clk_i),
    .we_i    (load_fire && (map_sel_e'(pix_i.map_select) == MAP_BLUE)),
    .waddr_i (pix_i.map_index),
    .wdata_i (pix_i.map_value[MapValW-1 -: CompW]),
    .re_i    (pix_fire),
    .raddr_i (pix_i.blue),
    .rdata_o (blue_map)
  );

  // Pixel register and byte sequencer.
  logic                pix_valid_q, pix_valid_d;
  logic [CompW-1:0]    red_q, green_q, blue_q;
  logic [ByteIdxW-1:0] idx_q, idx_d;
  logic [DimW-1:0]     col_q, col_d, row_q, row_d;
  logic                hdr_sent_q, hdr_sent_d;
  logic                row_end, frame_end, has_pad, emit, is_last, finish;
  logic [ByteIdxW-1:0] last_idx;
  logic [7:0]          byte_val;

  assign row_end   = ({1'b0, col_q} + (DimW+1)'(1)) >= {1'b0, width_eff};
  assign frame_end = row_end
                   && (({1'b0, row_q} + (DimW+1)'(1)) >= {1'b0, height_eff});
  assign has_pad   = row_end && width_eff[0];
  assign last_idx  = has_pad ? IdxPad : IdxBlue;

  assign emit    = pix_valid_q && (!byte_o.valid || byte_o.ready);
  assign is_last = (idx_q == last_idx);
  assign finish  = emit && is_last;

  assign pix_i.ready = !pix_valid_q || finish;

  always_comb begin
    if (!idx_q[ByteIdxW-1]) begin
      byte_val = header_byte(idx_q[4:0], width_eff, height_eff, length_q);
    end else begin
      case (idx_q)
        IdxRed:   byte_val = map_en_q[0] ? red_map   : red_q;
        IdxGreen: byte_val = map_en_q[1] ? green_map : green_q;
        IdxBlue:  byte_val = map_en_q[2] ? blue_map  : blue_q;
        default:  byte_val = 8'd0;
      endcase
    end
  end

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    hdr_sent_d = hdr_sent_q;
    if (finish) begin
      hdr_sent_d = !frame_end;
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + DimW'(1);
      end else begin
        col_d = col_q + DimW'(1);
      end
    end
  end

  always_comb begin
    pix_valid_d = pix_valid_q;
    idx_d       = idx_q;
    if (emit) begin
      idx_d = idx_q + ByteIdxW'(1);
    end
    if (finish) begin
      pix_valid_d = 1'b0;
    end
    // A pixel starts at the header unless the header of its frame is out.
    if (pix_fire) begin
      pix_valid_d = 1'b1;
      idx_d       = hdr_sent_d ? IdxRed : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_valid_q <= 1'b0;
      idx_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      hdr_sent_q  <= 1'b0;
    end else begin
      pix_valid_q <= pix_valid_d;
      idx_q       <= idx_d;
      col_q       <= col_d;
      row_q       <= row_d;
      hdr_sent_q  <= hdr_sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      red_q   <= pix_i.red;
      green_q <= pix_i.green;
      blue_q  <= pix_i.blue;
    end
  end

  // Output register.
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q, out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (byte_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= byte_val;
      out_last_q <= is_last;
      out_done_q <= is_last && frame_end;
    end
  end

  assign byte_o.valid        = out_valid_q;
  assign byte_o.out_byte     = out_byte_q;
  assign byte_o.last_of_item = out_last_q;
  assign byte_o.frame_done   = out_done_q;

  // Checks.
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> out_last_q)
    else $error("frame_done without last_of_item");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_q |-> (idx_q <= IdxPad))
    else $error("byte index beyond the pad byte");

  a_pad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (idx_q == IdxPad)) |=> (out_byte_q == 8'd0))
    else $error("pad byte is not zero");

  a_header_on_new_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_fire && !hdr_sent_d) |=> (idx_q == '0))
    else $error("new frame does not start with the header");

endmodule

@@ src/rsf_map_ram.sv @@
// ----------------------------------------------------------------------------
// rsf_map_ram
// 256 x 8 component map with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rsf_map_ram import rsf_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [CompW-1:0] waddr_i,
  input  logic [CompW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [CompW-1:0] raddr_i,
  output logic [CompW-1:0] rdata_o
);

  logic [CompW-1:0] mem [2**CompW];
  logic [CompW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // The read data is held until the next read, so it stays valid while the
  // pixel waits for the output side.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ dv/tb_rgb_raster_stream_framer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_raster_stream_framer
// Self-checking bench for the raster framer. A local predictor tracks the
// maps, counters and header state and builds the expected byte stream for
// every accepted item. A checker compares each output transfer against it.
// Directed tests cover reset defaults, map extremes, zero dimensions and a
// resize in the middle of a frame. Random frames with load noise and
// truncated frames follow, under bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_rgb_raster_stream_framer import rsf_pkg::*; ();

  localparam int          DrainCycles = 16;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int          RandomItems = 445;

  typedef struct packed {
    cmd_e                cmd;
    logic [CompW-1:0]    red;
    logic [CompW-1:0]    green;
    logic [CompW-1:0]    blue;
    map_sel_e            map_select;
    logic [CompW-1:0]    map_index;
    logic [MapValW-1:0]  map_value;
  } pix_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } raster_byte_t;

  logic clk_i;
  logic rst_ni;

  rsf_in_if  pix_if ();
  rsf_out_if byte_if ();
  rsf_cfg_if cfg_if ();

  rgb_raster_stream_framer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .byte_o (byte_if),
    .cfg_i  (cfg_if)
  );

  // Predicted state of the block.
  logic [DimW-1:0]   cur_width;
  logic [DimW-1:0]   cur_height;
  logic [MapEnW-1:0] cur_map_en;
  logic [DimW-1:0]   col_cnt;
  logic [DimW-1:0]   row_cnt;
  logic              hdr_sent;
  logic [7:0]        comp_map   [3][256];
  bit                map_loaded [3][256];

  raster_byte_t raster_bytes_q [$];
  raster_byte_t want_byte;
  raster_byte_t got_byte;

  int          burst_left   = 0;
  int          pixels_sent  = 0;
  int          loads_sent   = 0;
  int          bytes_seen   = 0;
  int          frames_seen  = 0;
  int          mismatches   = 0;
  int unsigned cycle_cnt    = 0;

  // Receiver stall pattern state.
  int rx_mode      = 0;
  int rx_mode_left = 0;
  int rx_stall     = 0;
  int rx_tick      = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d bytes still expected", cycle_cnt,
               raster_bytes_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // The receiver switches between always ready, random stalls, a fixed
  // duty pattern and stall bursts.
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(32, 256);
    end else begin
      rx_mode_left--;
    end
    rx_tick++;
    case (rx_mode)
      0: byte_if.ready <= 1'b1;
      1: byte_if.ready <= ($urandom_range(0, 3) != 0);
      2: byte_if.ready <= ((rx_tick % 5) < 3);
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          byte_if.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_stall = $urandom_range(1, 5);
          byte_if.ready <= 1'b0;
        end else begin
          byte_if.ready <= 1'b1;
        end
      end
    endcase
  end

  function automatic void note_mismatch(string what, raster_byte_t want, raster_byte_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch (%s) at cycle %0d: expected byte %02h last %0b done %0b,",
               what, cycle_cnt, want.data, want.last, want.done);
      $display("  got byte %02h last %0b done %0b", got.data, got.last, got.done);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && byte_if.valid === 1'b1 && byte_if.ready === 1'b1) begin
      got_byte = '{byte_if.out_byte, byte_if.last_of_item, byte_if.frame_done};
      bytes_seen++;
      if (raster_bytes_q.size() == 0) begin
        note_mismatch("unexpected byte", '0, got_byte);
      end else begin
        want_byte = raster_bytes_q.pop_front();
        if (got_byte.data !== want_byte.data) note_mismatch("out_byte", want_byte, got_byte);
        else if (got_byte.last !== want_byte.last)
          note_mismatch("last_of_item", want_byte, got_byte);
        else if (got_byte.done !== want_byte.done)
          note_mismatch("frame_done", want_byte, got_byte);
        if (want_byte.done) frames_seen++;
      end
    end
  end

  // Builds the rasterfile bytes that one accepted item causes.
  function automatic void predict_raster_bytes(pix_item_t it);
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
    logic [31:0]     line_len;
    logic [31:0]     words [8];
    logic [31:0]     hdr_word;
    logic [7:0]      comp [3];
    logic [7:0]      seq [36];
    bit              row_end;
    bit              frame_end;
    int              n;
    n         = 0;
    frame_end = 0;
    if (it.cmd == CMD_LOAD) begin
      if (it.map_select != MAP_NONE) begin
        comp_map[int'(it.map_select)][it.map_index]   = it.map_value[15:8];
        map_loaded[int'(it.map_select)][it.map_index] = 1'b1;
      end
      return;
    end
    w = (cur_width == '0) ? DimW'(1) : cur_width;
    h = (cur_height == '0) ? DimW'(1) : cur_height;
    if (!hdr_sent) begin
      line_len = 32'(w) * 32'd3 + 32'(w[0]);
      words[0] = RasMagic;
      words[1] = 32'(w);
      words[2] = 32'(h);
      words[3] = RasDepth;
      words[4] = line_len * 32'(h);
      words[5] = RasTypeRgb;
      words[6] = 32'd0;
      words[7] = 32'd0;
      for (int k = 0; k < 32; k++) begin
        hdr_word = words[k >> 2];
        seq[n]   = hdr_word[31 - 8 * (k & 3) -: 8];
        n++;
      end
      hdr_sent = 1'b1;
    end
    comp[0] = it.red;
    comp[1] = it.green;
    comp[2] = it.blue;
    for (int c = 0; c < 3; c++) begin
      seq[n] = cur_map_en[c] ? comp_map[c][comp[c]] : comp[c];
      n++;
    end
    row_end = (int'(col_cnt) + 1) >= int'(w);
    if (row_end) begin
      if (w[0]) begin
        seq[n] = 8'h00;
        n++;
      end
      col_cnt   = '0;
      frame_end = (int'(row_cnt) + 1) >= int'(h);
      if (frame_end) begin
        row_cnt  = '0;
        hdr_sent = 1'b0;
      end else begin
        row_cnt = row_cnt + 1'b1;
      end
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      raster_bytes_q.push_back('{seq[k], (k == n - 1), (k == n - 1) && frame_end});
    end
  endfunction

  task automatic send_item(pix_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        pix_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    pix_if.valid      <= 1'b1;
    pix_if.cmd        <= it.cmd;
    pix_if.red        <= it.red;
    pix_if.green      <= it.green;
    pix_if.blue       <= it.blue;
    pix_if.map_select <= it.map_select;
    pix_if.map_index  <= it.map_index;
    pix_if.map_value  <= it.map_value;
    @(posedge clk_i);
    while (pix_if.ready !== 1'b1) @(posedge clk_i);
    predict_raster_bytes(it);
    burst_left--;
    if (it.cmd == CMD_PIXEL) pixels_sent++;
    else if (it.map_select != MAP_NONE) loads_sent++;
  endtask

  task automatic send_load(map_sel_e sel, logic [7:0] idx, logic [15:0] val);
    pix_item_t it;
    it.cmd        = CMD_LOAD;
    it.red        = 8'($urandom);
    it.green      = 8'($urandom);
    it.blue       = 8'($urandom);
    it.map_select = sel;
    it.map_index  = idx;
    it.map_value  = val;
    send_item(it);
  endtask

  // Entries of enabled maps are loaded on demand so that no unwritten entry is used.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [7:0] comp [3];
    pix_item_t  it;
    comp[0] = r;
    comp[1] = g;
    comp[2] = b;
    for (int c = 0; c < 3; c++) begin
      if (cur_map_en[c] && !map_loaded[c][comp[c]])
        send_load(map_sel_e'(c), comp[c], 16'($urandom));
    end
    it.cmd        = CMD_PIXEL;
    it.red        = r;
    it.green      = g;
    it.blue       = b;
    it.map_select = map_sel_e'($urandom_range(0, 3));
    it.map_index  = 8'($urandom);
    it.map_value  = 16'($urandom);
    send_item(it);
  endtask

  // Stops the sender until every expected byte has arrived, then lets the
  // pipeline settle so that trailing loads have landed too.
  task automatic wait_idle();
    pix_if.valid <= 1'b0;
    burst_left = 0;
    while (raster_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Keeps valid high; the caller lowers it after the last write of a group.
  task automatic write_reg(cfg_reg_e idx, logic [DimW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    case (idx)
      REG_WIDTH:  cur_width  = data;
      REG_HEIGHT: cur_height = data;
      REG_MAP_EN: cur_map_en = data[MapEnW-1:0];
      default:    ;
    endcase
  endtask

  task automatic set_frame(int w, int h, int en);
    wait_idle();
    write_reg(REG_WIDTH, DimW'(w));
    write_reg(REG_HEIGHT, DimW'(h));
    // Upper data bits are random; only the low three bits matter.
    write_reg(REG_MAP_EN, {11'($urandom), 3'(en)});
    cfg_if.valid <= 1'b0;
  endtask

  // Reset values: 1 x 1 frames, maps off, every pixel a frame of its own.
  task automatic test_default_frame();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
  endtask

  task automatic test_map_tables();
    wait_idle();
    for (int c = 0; c < 3; c++) begin
      send_load(map_sel_e'(c), 8'h00, 16'h0000);
      send_load(map_sel_e'(c), 8'hff, 16'hffff);
      send_load(map_sel_e'(c), 8'h5a, 16'ha5ff);
    end
    // A load to the fourth select must leave every map untouched.
    send_load(MAP_NONE, 8'h00, 16'h1234);
    set_frame(2, 2, 7);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'hff, 8'h5a);
    send_pixel(8'h5a, 8'h00, 8'hff);
    set_frame(3, 1, 5);
    send_pixel(8'hff, 8'h00, 8'h5a);
    send_pixel(8'h5a, 8'h12, 8'h00);
    send_pixel(8'h00, 8'hff, 8'hff);
  endtask

  task automatic test_zero_dims();
    set_frame(0, 0, 0);
    send_pixel(8'h81, 8'h42, 8'h24);
    send_pixel(8'h7e, 8'hbd, 8'hdb);
  endtask

  // The header keeps the large dimensions; shrinking them ends the frame.
  task automatic test_resize_mid_frame();
    set_frame(16383, 16383, 0);
    send_pixel(8'h01, 8'h02, 8'h03);
    send_pixel(8'hfe, 8'hfd, 8'hfc);
    wait_idle();
    write_reg(REG_NONE, 14'h3fff);
    write_reg(REG_WIDTH, 14'd1);
    write_reg(REG_HEIGHT, 14'd1);
    cfg_if.valid <= 1'b0;
    send_pixel(8'h55, 8'haa, 8'h55);
  endtask

  task automatic test_random_frames();
    int target;
    int phase;
    int w;
    int h;
    int eff_w;
    int eff_h;
    int frames;
    int cut;
    int pick;
    target = pixels_sent + loads_sent + RandomItems;
    phase  = 0;
    while (pixels_sent + loads_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) w = $urandom_range(1, 8);
      else if (pick < 95) w = $urandom_range(9, 24);
      else w = $urandom_range(0, 40);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : $urandom_range(1, 3);
      set_frame(w, h, $urandom_range(0, 7));
      eff_w  = (w == 0) ? 1 : w;
      eff_h  = (h == 0) ? 1 : h;
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        // Now and then a frame is cut short and the next phase resizes it.
        cut = ($urandom_range(0, 24) == 0) ? $urandom_range(1, eff_w * eff_h) :
                                             eff_w * eff_h;
        for (int p = 0; p < cut; p++) begin
          if ($urandom_range(0, 11) == 0)
            send_load(map_sel_e'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
          send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
          if (phase == 3 && f == 0 && p == cut / 2) wait_idle();
        end
      end
      phase++;
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    pix_if.valid      = 1'b0;
    pix_if.cmd        = CMD_LOAD;
    pix_if.red        = '0;
    pix_if.green      = '0;
    pix_if.blue       = '0;
    pix_if.map_select = MAP_RED;
    pix_if.map_index  = '0;
    pix_if.map_value  = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_WIDTH;
    cfg_if.data       = '0;
    cur_width         = DimW'(1);
    cur_height        = DimW'(1);
    cur_map_en        = '0;
    col_cnt           = '0;
    row_cnt           = '0;
    hdr_sent          = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_frame();
    test_map_tables();
    test_zero_dims();
    test_resize_mid_frame();
    test_random_frames();
    wait_idle();

    $display("Sent %0d pixels and %0d map loads; checked %0d bytes over %0d frames.",
             pixels_sent, loads_sent, bytes_seen, frames_seen);
    $display("Covered zero and maximum dimensions, resizes mid-frame, all maps, %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
